// ----- hdl/gba_pkg.sv -----
// Shared types and constants for the growable bitmap allocator.
// Used by gba_core and growable_bitmap_allocator; depends on nothing.
package gba_pkg;

   localparam int CAPACITY_BITS_DEF = 4096;
   localparam int INIT_BITS_RESET   = 64;

   localparam int OP_W          = 3;
   localparam int BIT_INDEX_W   = 16;
   localparam int STATUS_W      = 2;
   localparam int POSITION_W    = 13;
   localparam int INIT_BITS_W   = 13;
   localparam int REQ_TDATA_W   = 24;
   localparam int RSP_TDATA_W   = 16;

   localparam logic [OP_W-1:0] OP_SET    = 3'd0;
   localparam logic [OP_W-1:0] OP_CLR    = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLRALL = 3'd3;
   localparam logic [OP_W-1:0] OP_SETALL = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NORES = 2'd2;

   localparam logic [7:0] BYTE_ONES = 8'hff;

   typedef struct packed {
      logic [POSITION_W-1:0] position;
      logic                  is_set;
      logic [STATUS_W-1:0]   status;
   } gba_res_type;

endpackage

// ----- hdl/gba_core.sv -----
// Sequencer and byte store of the bitmap allocator.
// Depends on gba_pkg; the store reads one byte and writes at most one byte per cycle.
module gba_core #(
   parameter int CAPACITY_BITS = gba_pkg::CAPACITY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cfg_we,
   input  logic [gba_pkg::INIT_BITS_W-1:0]     cfg_value,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  logic [gba_pkg::OP_W-1:0]            item_op,
   input  logic [gba_pkg::BIT_INDEX_W-1:0]     item_bit,
   output logic                                res_valid,
   input  logic                                res_ready,
   output gba_pkg::gba_res_type                res
);
   import gba_pkg::*;

   localparam int STORE_BYTES = (CAPACITY_BITS + 7) / 8;
   localparam int GROW_LIMIT  = CAPACITY_BITS / 8;
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int BC_W        = $clog2(STORE_BYTES + 1);
   localparam int LB_W        = $clog2(CAPACITY_BITS + 1);
   localparam int BIT_W       = (BC_W + 3 > BIT_INDEX_W) ? BC_W + 3 : BIT_INDEX_W;
   localparam int IDX_W       = BIT_W - 3;
   localparam int CW          = BIT_W;
   localparam int RST_BITS    = (INIT_BITS_RESET > CAPACITY_BITS) ? CAPACITY_BITS
                                                                  : INIT_BITS_RESET;
   localparam int RST_BC      = (RST_BITS + 7) / 8;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_INIT  = 9'b000000010,
      S_DISP  = 9'b000000100,
      S_RMW   = 9'b000001000,
      S_FILL  = 9'b000010000,
      S_FIND  = 9'b000100000,
      S_GROW  = 9'b001000000,
      S_ZFILL = 9'b010000000,
      S_RESP  = 9'b100000000
   } gba_state_type;

   gba_state_type      state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [BC_W-1:0]    bc_ff, bc_in;
   logic [LB_W-1:0]    legal_ff, legal_in;
   logic [BC_W-1:0]    scan_ff, scan_in;
   logic [BC_W:0]      grown_ff, grown_in;
   gba_res_type        res_ff, res_in;

   logic [7:0]         mem [STORE_BYTES];
   logic [7:0]         rdata_ff;
   logic [AW-1:0]      rd_addr;
   logic               we;
   logic [AW-1:0]      wa;
   logic [7:0]         wd;

   logic [IDX_W-1:0]   idx;
   logic [CW-1:0]      idx_c, bc_c, legal_c, scan_c, scan_inc_c, grown_c;
   logic [7:0]         mask;
   logic [2:0]         zero_k;
   logic               cfg_clamp;
   logic [LB_W-1:0]    cfg_bits;
   logic [BC_W-1:0]    cfg_bc;

   assign idx        = bit_ff[BIT_W-1:3];
   assign idx_c      = CW'(idx);
   assign bc_c       = CW'(bc_ff);
   assign legal_c    = CW'(legal_ff);
   assign scan_c     = CW'(scan_ff);
   assign scan_inc_c = CW'(scan_ff) + CW'(1);
   assign grown_c    = CW'(grown_ff);
   assign mask       = 8'd1 << bit_ff[2:0];

   assign cfg_clamp = (32'(cfg_value) > 32'(CAPACITY_BITS));
   assign cfg_bits  = cfg_clamp ? LB_W'(CAPACITY_BITS) : LB_W'(cfg_value);
   assign cfg_bc    = BC_W'((32'(cfg_bits) + 32'd7) >> 3);

   always_comb begin
      zero_k = 3'd7;
      for (int j = 6; j >= 0; j--) begin
         if (!rdata_ff[j]) begin
            zero_k = 3'(j);
         end
      end
   end

   assign item_ready = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_RESP);
   assign res        = res_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      bit_in   = bit_ff;
      bc_in    = bc_ff;
      legal_in = legal_ff;
      scan_in  = scan_ff;
      grown_in = grown_ff;
      res_in   = res_ff;
      we       = 1'b0;
      wa       = AW'(scan_ff);
      wd       = 8'd0;
      rd_addr  = AW'(idx);

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               op_in    = item_op;
               bit_in   = BIT_W'(item_bit);
               state_in = S_DISP;
            end
         end
         S_INIT: begin
            we = 1'b1;
            if (scan_inc_c >= bc_c) begin
               state_in = S_IDLE;
            end else begin
               scan_in = BC_W'(scan_inc_c);
            end
         end
         S_DISP: begin
            res_in = '0;
            if (op_ff == OP_FIND) begin
               rd_addr = '0;
            end
            unique case (op_ff) inside
               OP_SET: begin
                  if (idx_c < bc_c) begin
                     state_in = S_RMW;
                  end else begin
                     grown_in = (BC_W+1)'(bc_ff);
                     state_in = S_GROW;
                  end
               end
               OP_CLR, OP_TEST: begin
                  if (bit_ff >= legal_c || idx_c >= bc_c) begin
                     res_in.status = ST_BAD;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_RMW;
                  end
               end
               OP_CLRALL, OP_SETALL: begin
                  scan_in  = '0;
                  state_in = S_FILL;
               end
               OP_FIND: begin
                  scan_in  = '0;
                  state_in = S_FIND;
               end
               default: begin
                  res_in.status = ST_BAD;
                  state_in      = S_RESP;
               end
            endcase
         end
         S_RMW: begin
            wa = AW'(idx);
            case (op_ff)
               OP_SET: begin
                  we = 1'b1;
                  wd = rdata_ff | mask;
               end
               OP_CLR: begin
                  we = 1'b1;
                  wd = rdata_ff & ~mask;
               end
               default: begin
                  res_in.is_set = rdata_ff[bit_ff[2:0]];
               end
            endcase
            state_in = S_RESP;
         end
         S_FILL: begin
            we = 1'b1;
            wd = (op_ff == OP_SETALL) ? BYTE_ONES : 8'd0;
            if (scan_inc_c >= bc_c) begin
               state_in = S_RESP;
            end else begin
               scan_in = BC_W'(scan_inc_c);
            end
         end
         S_FIND: begin
            rd_addr = AW'(scan_inc_c);
            if (rdata_ff != BYTE_ONES) begin
               we              = 1'b1;
               wd              = rdata_ff | (8'd1 << zero_k);
               res_in.position = POSITION_W'({scan_ff, zero_k});
               state_in        = S_RESP;
            end else if (scan_inc_c >= bc_c) begin
               bit_in   = BIT_W'({bc_ff, 3'b000});
               grown_in = (BC_W+1)'(bc_ff);
               state_in = S_GROW;
            end else begin
               scan_in = BC_W'(scan_inc_c);
            end
         end
         S_GROW: begin
            if (grown_c > CW'(GROW_LIMIT)) begin
               res_in.status = ST_NORES;
               state_in      = S_RESP;
            end else if (grown_c <= idx_c) begin
               grown_in = grown_ff + (BC_W+1)'(bc_ff);
            end else begin
               scan_in  = bc_ff;
               state_in = S_ZFILL;
            end
         end
         S_ZFILL: begin
            we = 1'b1;
            wd = (scan_c == idx_c) ? mask : 8'd0;
            if (scan_inc_c >= grown_c) begin
               bc_in    = BC_W'(grown_ff);
               legal_in = LB_W'(bit_ff + BIT_W'(1));
               if (op_ff == OP_FIND) begin
                  res_in.position = POSITION_W'(bit_ff);
               end
               state_in = S_RESP;
            end else begin
               scan_in = BC_W'(scan_inc_c);
            end
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_we && cfg_value != '0) begin
         legal_in = cfg_bits;
         bc_in    = cfg_bc;
         scan_in  = '0;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         bc_ff    <= BC_W'(RST_BC);
         legal_ff <= LB_W'(RST_BITS);
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bc_ff    <= bc_in;
         legal_ff <= legal_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      bit_ff   <= bit_in;
      grown_ff <= grown_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_bc_range: assert property (@(posedge clock) disable iff (reset)
      bc_ff != '0 && 32'(bc_ff) <= 32'(GROW_LIMIT > RST_BC ? STORE_BYTES : STORE_BYTES))
      else $error("byte count out of range");

   a_legal_range: assert property (@(posedge clock) disable iff (reset)
      32'(legal_ff) <= 32'(CAPACITY_BITS))
      else $error("legal bit count above capacity");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      we && state_ff != S_ZFILL |-> CW'(wa) < bc_c)
      else $error("store write beyond byte count");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      item_valid && item_ready && !cfg_we |=> state_ff == S_DISP)
      else $error("accepted item not dispatched");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res.status == ST_OK || res.status == ST_BAD || res.status == ST_NORES)
      else $error("undefined status code");
`endif

endmodule

// ----- hdl/growable_bitmap_allocator.sv -----
// Each item is dispatched, then set/clear/test in range do a read-modify-write of one
// byte; clear all and set all walk byte_count bytes; find scans the bytes; growth steps
// through the multiples and then zero-fills each new byte. One item at a time; a new
// item is taken only once the last result has left the core. After reset, and after each
// nonzero initial_bits write, a clearing pass over ceil(initial_bits/8) bytes (8 after reset)
// runs before req_tready. Synchronous active-high reset; depends on gba_pkg, gba_core.
module growable_bitmap_allocator #(
   parameter int CAPACITY_BITS = gba_pkg::CAPACITY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gba_pkg::REQ_TDATA_W-1:0]     req_tdata,   // op[2:0], bit_index[18:3]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gba_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // status[1:0], is_set[2],
                                                            // position[15:3]
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gba_pkg::INIT_BITS_W-1:0]     csr_data
);
   import gba_pkg::*;

   logic          res_valid;
   logic          res_ready;
   gba_res_type   res;
   logic          rsp_valid_ff, rsp_valid_in;
   gba_res_type   rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   gba_core #(
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg_we     (csr_valid),
      .cfg_value  (csr_data),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item_op    (req_tdata[OP_W-1:0]),
      .item_bit   (req_tdata[OP_W+BIT_INDEX_W-1:OP_W]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.position, rsp_data_ff.is_set, rsp_data_ff.status};

endmodule

// ----- verif/tb_growable_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for growable_bitmap_allocator: a directed set of items, then random
// phases under several initial_bits settings and idle patterns, each result checked against
// a bitmap mirror. Depends on gba_pkg and the allocator RTL.
module tb_growable_bitmap_allocator;
   import gba_pkg::*;

   localparam int STORE_BYTES = CAPACITY_BITS_DEF / 8;
   localparam logic [OP_W-1:0] OP_BAD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_BAD7 = 3'd7;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 1200;

   typedef struct packed {
      logic [BIT_INDEX_W-1:0] bit_index;
      logic [OP_W-1:0]        op;
   } alloc_req_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [INIT_BITS_W-1:0] csr_data = '0;

   alloc_req_type req_backlog[$];
   gba_res_type   results_due[$];
   alloc_req_type drv_item;

   logic [7:0]  mirror_store [0:STORE_BYTES-1];
   int unsigned mirror_bytes;
   int unsigned mirror_legal;

   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int rx_hold_arm = 0;
   int rx_hold_seen = 0;
   int rx_hold_left = 0;
   int fail_count = 0;
   int items_sent = 0;
   int csr_writes = 0;
   int status_seen [0:3] = '{0, 0, 0, 0};

   growable_bitmap_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void mirror_load(int unsigned bits);
      if (bits == 0) return;
      if (bits > CAPACITY_BITS_DEF) bits = CAPACITY_BITS_DEF;
      mirror_legal = bits;
      mirror_bytes = (bits + 7) / 8;
      for (int k = 0; k < STORE_BYTES; k++) mirror_store[k] = 8'h00;
   endfunction

   function automatic logic [STATUS_W-1:0] mirror_set(int unsigned b);
      int unsigned idx;
      int unsigned grown;
      idx = b / 8;
      if (mirror_bytes == 0) return ST_NORES;
      if (idx >= mirror_bytes) begin
         grown = (idx / mirror_bytes + 1) * mirror_bytes;
         if (grown * 8 > CAPACITY_BITS_DEF) return ST_NORES;
         for (int k = mirror_bytes; k < grown; k++) mirror_store[k] = 8'h00;
         mirror_bytes = grown;
         mirror_legal = b + 1;
      end
      mirror_store[idx][b % 8] = 1'b1;
      return ST_OK;
   endfunction

   function automatic gba_res_type bitmap_apply(alloc_req_type it);
      gba_res_type res;
      int unsigned b;
      int unsigned i;
      int unsigned k;
      int unsigned p;
      res = '0;
      b = 32'(it.bit_index);
      case (it.op) inside
         OP_SET: begin
            res.status = mirror_set(b);
         end
         OP_CLR, OP_TEST: begin
            if (b >= mirror_legal || b / 8 >= mirror_bytes) begin
               res.status = ST_BAD;
            end else if (it.op == OP_CLR) begin
               mirror_store[b / 8][b % 8] = 1'b0;
            end else begin
               res.is_set = mirror_store[b / 8][b % 8];
            end
         end
         OP_CLRALL: begin
            for (i = 0; i < mirror_bytes; i++) mirror_store[i] = 8'h00;
         end
         OP_SETALL: begin
            for (i = 0; i < mirror_bytes; i++) mirror_store[i] = BYTE_ONES;
         end
         OP_FIND: begin
            i = 0;
            while (i < mirror_bytes && mirror_store[i] == BYTE_ONES) i++;
            if (i >= mirror_bytes) begin
               p = mirror_bytes * 8;
               res.status = mirror_set(p);
               if (res.status == ST_OK) res.position = p[POSITION_W-1:0];
            end else begin
               k = 0;
               while (k < 7 && mirror_store[i][k]) k++;
               mirror_store[i][k] = 1'b1;
               p = i * 8 + k;
               res.position = p[POSITION_W-1:0];
            end
         end
         default: begin
            res.status = ST_BAD;
         end
      endcase
      return res;
   endfunction

   function automatic alloc_req_type random_req();
      alloc_req_type it;
      int unsigned r;
      int unsigned s;
      r = $urandom_range(99);
      s = $urandom_range(99);
      if (r < 24) it.op = OP_SET;
      else if (r < 38) it.op = OP_CLR;
      else if (r < 56) it.op = OP_TEST;
      else if (r < 60) it.op = OP_CLRALL;
      else if (r < 65) it.op = OP_SETALL;
      else if (r < 97) it.op = OP_FIND;
      else it.op = ($urandom_range(1) != 0) ? OP_BAD7 : OP_BAD6;
      if (s < 70) it.bit_index = BIT_INDEX_W'($urandom_range(mirror_legal - 1));
      else if (s < 88) it.bit_index = BIT_INDEX_W'($urandom_range(mirror_bytes * 16 - 1));
      else if (s < 95) it.bit_index = BIT_INDEX_W'($urandom_range(CAPACITY_BITS_DEF + 63));
      else it.bit_index = BIT_INDEX_W'($urandom());
      return it;
   endfunction

   task automatic add_req(logic [OP_W-1:0] op, logic [BIT_INDEX_W-1:0] bit_index);
      alloc_req_type it;
      it.op = op;
      it.bit_index = bit_index;
      req_backlog.push_back(it);
   endtask

   task automatic note_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_result(gba_res_type got);
      gba_res_type want;
      if (results_due.size() == 0) begin
         note_fail($sformatf("unexpected result status=%0d is_set=%0d position=%0d",
                             got.status, got.is_set, got.position));
      end else begin
         want = results_due.pop_front();
         status_seen[got.status]++;
         if (got.status !== want.status)
            note_fail($sformatf("status expected %0d, got %0d", want.status, got.status));
         if (got.is_set !== want.is_set)
            note_fail($sformatf("is_set expected %0d, got %0d", want.is_set, got.is_set));
         if (got.position !== want.position)
            note_fail($sformatf("position expected %0d, got %0d",
                                want.position, got.position));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            results_due.push_back(bitmap_apply(drv_item));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               drv_item = req_backlog.pop_front();
               req_tdata <= REQ_TDATA_W'({drv_item.bit_index, drv_item.op});
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(gba_res_type'(rsp_tdata));
         rsp_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (rx_hold_arm != rx_hold_seen) begin
         rx_hold_seen <= rx_hold_arm;
         rx_hold_left <= HOLD_CYCLES;
      end else if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end
   end

   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_tvalid || results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_init_bits(logic [INIT_BITS_W-1:0] value);
      @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mirror_load(32'(value));
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic set_pacing(int tx, int rx);
      tx_idle_pct = tx;
      rx_stall_pct = rx;
   endtask

   task automatic feed_random(int n);
      int chunk;
      while (n > 0) begin
         while (req_backlog.size() >= 4) @(negedge clock);
         chunk = (n < 25) ? n : 25;
         for (int k = 0; k < chunk; k++) req_backlog.push_back(random_req());
         n -= chunk;
      end
   endtask

   task automatic run_phase(logic [INIT_BITS_W-1:0] value, int n, int tx, int rx);
      wait_idle();
      write_init_bits(value);
      set_pacing(tx, rx);
      feed_random(n);
   endtask

   initial begin
      mirror_bytes = 0;
      mirror_legal = 0;
      mirror_load(INIT_BITS_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items on the reset sizing of 64 bits
      set_pacing(0, 0);
      add_req(OP_SET, 16'd0);
      add_req(OP_SET, 16'd63);
      add_req(OP_TEST, 16'd0);
      add_req(OP_TEST, 16'd63);
      add_req(OP_TEST, 16'd64);
      add_req(OP_CLR, 16'd64);
      add_req(OP_CLR, 16'd0);
      add_req(OP_TEST, 16'd0);
      add_req(OP_SET, 16'd64);
      add_req(OP_SET, 16'd70);
      add_req(OP_TEST, 16'd70);
      add_req(OP_FIND, 16'd0);
      add_req(OP_SETALL, 16'd0);
      add_req(OP_FIND, 16'd0);
      add_req(OP_TEST, 16'hffff);
      add_req(OP_CLR, 16'hffff);
      add_req(OP_SET, 16'hffff);
      add_req(OP_SET, 16'd4095);
      add_req(OP_BAD6, 16'd0);
      add_req(OP_BAD7, 16'h5a5a);
      add_req(OP_CLRALL, 16'd0);
      add_req(OP_TEST, 16'd1);
      add_req(OP_FIND, 16'hffff);

      run_phase(13'd1, 300, 0, 0);

      // Full capacity: a find on a full store cannot grow
      wait_idle();
      write_init_bits(13'd4096);
      set_pacing(24, 24);
      add_req(OP_SETALL, 16'd0);
      add_req(OP_FIND, 16'd0);
      add_req(OP_SET, 16'd4095);
      add_req(OP_TEST, 16'd4095);
      add_req(OP_CLRALL, 16'd0);
      feed_random(35);

      run_phase(13'd0, 30, 0, 80);
      run_phase(13'h1fff, 20, 24, 24);
      run_phase(13'd13, 350, 80, 0);

      // Long receiver hold while items keep coming
      wait_idle();
      write_init_bits(13'd37);
      set_pacing(0, 80);
      rx_hold_arm++;
      feed_random(350);

      run_phase(13'd4097, 15, 0, 0);
      run_phase(13'd200, 300, 24, 24);

      // Sender pauses mid-phase until every result is back
      run_phase(13'd8, 150, 0, 0);
      wait_idle();
      feed_random(150);

      run_phase(13'd3, 150, 24, 24);

      wait_idle();
      set_pacing(0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (results_due.size() != 0)
         note_fail($sformatf("%0d results never arrived", results_due.size()));

      $display("Run covered %0d items over %0d initial_bits writes and four pacing modes.",
               items_sent, csr_writes);
      $display("Results: %0d success, %0d bad parameter, %0d out of resource; %0d failures.",
               status_seen[ST_OK], status_seen[ST_BAD], status_seen[ST_NORES], fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #120_000_000;
      $display("Timeout with %0d results outstanding", results_due.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
